### sv/bgfl_pkg.sv
// ----------------------------------------------------------------------------
// Block-grown free list allocator: shared package
// Sizes, command and status codes, and the structs passed between modules.
// ----------------------------------------------------------------------------
package bgfl_pkg;

   localparam int BLOCKS          = 16;
   localparam int SLOTS_PER_BLOCK = 64;
   localparam int TOTAL_SLOTS     = BLOCKS * SLOTS_PER_BLOCK;

   // field widths
   localparam int ADDR_W  = 11;
   localparam int BLK_W   = 4;
   localparam int SLOT_W  = 6;
   localparam int OFF_W   = 18;
   localparam int SIZE_W  = 13;
   localparam int CMD_W   = 2;
   localparam int STAT_W  = 2;

   localparam int IDX_W    = $clog2(TOTAL_SLOTS);
   localparam int GROWN_W  = $clog2(BLOCKS + 1);
   localparam int ENTRY_W  = ADDR_W + 1;           // {in_use, next_link}

   localparam int REQ_DATA_W = 16;
   localparam int RSP_FLDS_W = ADDR_W + BLK_W + SLOT_W + OFF_W;
   localparam int RSP_DATA_W = ((RSP_FLDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W  = RSP_DATA_W - RSP_FLDS_W;

   localparam logic [ADDR_W-1:0] ADDR_NONE    = '1;
   localparam logic [SIZE_W-1:0] SIZE_RESET   = SIZE_W'(16);
   localparam logic [SIZE_W-1:0] SIZE_MAX     = SIZE_W'(4096);

   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC  = 2'd0,
      CMD_FREE   = 2'd1,
      CMD_LOOKUP = 2'd2,
      CMD_CLEAR  = 2'd3
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK         = 2'd0,
      ST_POOL_FULL  = 2'd1,
      ST_NOT_IN_USE = 2'd2,
      ST_OUTSIDE    = 2'd3
   } status_type;

   typedef struct packed {
      logic              valid;
      logic [ADDR_W-1:0] addr;
      status_type        status;
   } fin_type;

   typedef struct packed {
      logic               we;
      logic [IDX_W-1:0]   waddr;
      logic [ENTRY_W-1:0] wdata;
      logic [IDX_W-1:0]   raddr;
   } ram_req_type;

   // address lies inside the blocks grown so far
   function automatic logic in_grown(logic [ADDR_W-1:0] a, logic [GROWN_W-1:0] g);
      return !a[ADDR_W-1] && (GROWN_W'(a[IDX_W-1:SLOT_W]) < g);
   endfunction

   function automatic logic [SIZE_W-1:0] clamp_size(logic [SIZE_W-1:0] s);
      logic [SIZE_W-1:0] r;
      r = s;
      if (s == '0) r = SIZE_W'(1);
      else if (s > SIZE_MAX) r = SIZE_MAX;
      return r;
   endfunction

endpackage

### sv/bgfl_ram.sv
// ----------------------------------------------------------------------------
// Slot table RAM
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bgfl_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 12
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### sv/bgfl_ctrl.sv
// ----------------------------------------------------------------------------
// Allocator sequencer
// Reads a slot entry, modifies and writes it back; threads new blocks.
// ----------------------------------------------------------------------------
module bgfl_ctrl import bgfl_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  cmd_type            req_cmd,
   input  logic [ADDR_W-1:0]  req_addr,
   input  logic               out_free,
   output fin_type            fin,
   output ram_req_type        ram,
   input  logic [ENTRY_W-1:0] ram_rdata
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_GROW,
      S_WAIT
   } state_type;

   state_type            state_ff, state_in;
   cmd_type              cmd_ff, cmd_in;
   logic [ADDR_W-1:0]    addr_ff, addr_in;
   logic [ADDR_W-1:0]    head_ff, head_in;
   logic [GROWN_W-1:0]   grown_ff, grown_in;
   logic [SLOT_W-1:0]    cnt_ff, cnt_in;
   fin_type              pend_ff, pend_in;
   fin_type              res;
   logic                 rd_use;
   logic [ADDR_W-1:0]    rd_link;
   logic [IDX_W-1:0]     grow_slot;
   logic                 grow_last;

   assign rd_use    = ram_rdata[ENTRY_W-1];
   assign rd_link   = ram_rdata[ADDR_W-1:0];
   assign grow_slot = {grown_ff[BLK_W-1:0], cnt_ff};
   assign grow_last = (cnt_ff == SLOT_W'(SLOTS_PER_BLOCK - 1));
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      addr_in  = addr_ff;
      head_in  = head_ff;
      grown_in = grown_ff;
      cnt_in   = cnt_ff;
      pend_in  = pend_ff;
      res      = '{valid: 1'b0, addr: ADDR_NONE, status: ST_OK};
      ram      = '0;
      ram.raddr = head_ff[IDX_W-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in  = req_cmd;
               addr_in = req_addr;
               unique case (req_cmd)
                  CMD_ALLOC: begin
                     if (head_ff != ADDR_NONE) begin
                        state_in = S_READ;
                     end else if (grown_ff == GROWN_W'(BLOCKS)) begin
                        res = '{valid: 1'b1, addr: ADDR_NONE, status: ST_POOL_FULL};
                     end else begin
                        cnt_in   = '0;
                        state_in = S_GROW;
                     end
                  end
                  CMD_FREE, CMD_LOOKUP: begin
                     ram.raddr = req_addr[IDX_W-1:0];
                     if (req_cmd == CMD_LOOKUP && req_addr == ADDR_NONE) begin
                        res = '{valid: 1'b1, addr: ADDR_NONE, status: ST_OK};
                     end else if (!in_grown(req_addr, grown_ff)) begin
                        res = '{valid: 1'b1, addr: ADDR_NONE, status: ST_OUTSIDE};
                     end else begin
                        state_in = S_READ;
                     end
                  end
                  CMD_CLEAR: begin
                     head_in  = ADDR_NONE;
                     grown_in = '0;
                     res = '{valid: 1'b1, addr: ADDR_NONE, status: ST_OK};
                  end
                  default: ;
               endcase
            end
         end
         S_READ: begin
            state_in = S_IDLE;
            if (cmd_ff == CMD_ALLOC) begin
               ram.we    = 1'b1;
               ram.waddr = head_ff[IDX_W-1:0];
               ram.wdata = {1'b1, ADDR_NONE};
               head_in   = rd_link;
               res = '{valid: 1'b1, addr: head_ff, status: ST_OK};
            end else if (!rd_use) begin
               res = '{valid: 1'b1, addr: ADDR_NONE, status: ST_NOT_IN_USE};
            end else if (cmd_ff == CMD_FREE) begin
               ram.we    = 1'b1;
               ram.waddr = addr_ff[IDX_W-1:0];
               ram.wdata = {1'b0, head_ff};
               head_in   = addr_ff;
               res = '{valid: 1'b1, addr: addr_ff, status: ST_OK};
            end else begin
               res = '{valid: 1'b1, addr: addr_ff, status: ST_OK};
            end
         end
         S_GROW: begin
            // first slot of the new block goes straight out as allocated
            ram.we    = 1'b1;
            ram.waddr = grow_slot;
            if (cnt_ff == '0)
               ram.wdata = {1'b1, ADDR_NONE};
            else if (grow_last)
               ram.wdata = {1'b0, ADDR_NONE};
            else
               ram.wdata = {1'b0, ADDR_W'(grow_slot) + ADDR_W'(1)};
            cnt_in = cnt_ff + SLOT_W'(1);
            if (grow_last) begin
               grown_in = grown_ff + GROWN_W'(1);
               head_in  = (SLOTS_PER_BLOCK > 1) ?
                          ADDR_W'({grown_ff[BLK_W-1:0], SLOT_W'(1)}) : ADDR_NONE;
               state_in = S_IDLE;
               res = '{valid: 1'b1,
                       addr: ADDR_W'({grown_ff[BLK_W-1:0], SLOT_W'(0)}),
                       status: ST_OK};
            end
         end
         S_WAIT: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase

      if (res.valid && !out_free) begin
         pend_in  = res;
         state_in = S_WAIT;
      end
      fin = (state_ff == S_WAIT) ? pend_ff : res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= ADDR_NONE;
         grown_ff <= '0;
         cnt_ff   <= '0;
         pend_ff  <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         grown_ff <= grown_in;
         cnt_ff   <= cnt_in;
         pend_ff  <= pend_in;
      end
      cmd_ff  <= cmd_in;
      addr_ff <= addr_in;
   end

endmodule

### sv/bgfl_out.sv
// ----------------------------------------------------------------------------
// Result output stage
// Holds the object size register and the output word; splits the address.
// ----------------------------------------------------------------------------
module bgfl_out import bgfl_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   input  logic [SIZE_W-1:0]     csr_data,
   input  fin_type               fin,
   output logic                  out_free,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [STAT_W-1:0]     rsp_tuser
);

   logic [SIZE_W-1:0]        size_ff;
   logic                     valid_ff, valid_in;
   logic [ADDR_W-1:0]        addr_ff;
   logic [BLK_W-1:0]         blk_ff, blk_in;
   logic [SLOT_W-1:0]        slot_ff, slot_in;
   logic [OFF_W-1:0]         off_ff, off_in;
   status_type               stat_ff;
   logic [SLOT_W+SIZE_W-1:0] prod;

   assign out_free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff && !rsp_tready;
      if (out_free) valid_in = fin.valid;
      // none address and errors carry zero in the split fields
      blk_in  = fin.addr[ADDR_W-1] ? '0 : fin.addr[IDX_W-1:SLOT_W];
      slot_in = fin.addr[ADDR_W-1] ? '0 : fin.addr[SLOT_W-1:0];
      prod    = (SLOT_W+SIZE_W)'(slot_in) * (SLOT_W+SIZE_W)'(size_ff);
      off_in  = prod[OFF_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         size_ff  <= SIZE_RESET;
      end else begin
         valid_ff <= valid_in;
         if (csr_valid) size_ff <= clamp_size(csr_data);
      end
      if (out_free && fin.valid) begin
         addr_ff <= fin.addr;
         blk_ff  <= blk_in;
         slot_ff <= slot_in;
         off_ff  <= off_in;
         stat_ff <= fin.status;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, off_ff, slot_ff, blk_ff, addr_ff};
   assign rsp_tuser  = stat_ff;

endmodule

### sv/block_grown_free_list_allocator.sv
// Clear, pool full, none and out-of-range answers come from the idle state; lookup reads the
// slot entry, free and allocate from a non-empty list read it, then write it back. A grow
// writes the 64 slots of its block through the single RAM write port. Immediate answers
// come one word a cycle while the output is free; RAM words and grows hold off new requests,
// and the output register frees the input side. Reset clears the list head, the grown count
// and the size register (16); the slot RAM is not swept, as a grow rewrites each entry first.
// ----------------------------------------------------------------------------
// Block-grown free list allocator
// Slot allocator over a pool of fixed-size blocks, with a stream interface.
// ----------------------------------------------------------------------------
module block_grown_free_list_allocator import bgfl_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [SIZE_W-1:0]     csr_data,    // object_size
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // address[10:0], zero pad
   input  logic [CMD_W-1:0]      req_tuser,   // cmd[1:0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // result_address, block_index, slot_index,
                                              // byte_offset, zero pad
   output logic [STAT_W-1:0]     rsp_tuser    // status[1:0]
);

   fin_type            fin;
   ram_req_type        ram;
   logic               out_free;
   logic [ENTRY_W-1:0] ram_rdata;

   assign csr_ready = 1'b1;

   bgfl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_cmd   (cmd_type'(req_tuser)),
      .req_addr  (req_tdata[ADDR_W-1:0]),
      .out_free  (out_free),
      .fin       (fin),
      .ram       (ram),
      .ram_rdata (ram_rdata)
   );

   bgfl_ram #(
      .DEPTH (TOTAL_SLOTS),
      .WIDTH (ENTRY_W)
   ) u_ram (
      .clock (clock),
      .we    (ram.we),
      .waddr (ram.waddr),
      .wdata (ram.wdata),
      .raddr (ram.raddr),
      .rdata (ram_rdata)
   );

   bgfl_out u_out (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .fin        (fin),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

### sv/bgfl_checker.sv
// ----------------------------------------------------------------------------
// Allocator port checker
// Watches the top-level ports: output word stability and field consistency.
// ----------------------------------------------------------------------------
module bgfl_checker import bgfl_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [STAT_W-1:0]     rsp_tuser
);

   logic [ADDR_W-1:0] r_addr;
   logic [BLK_W-1:0]  r_blk;
   logic [SLOT_W-1:0] r_slot;
   logic [OFF_W-1:0]  r_off;

   assign r_addr = rsp_tdata[ADDR_W-1:0];
   assign r_blk  = rsp_tdata[ADDR_W+BLK_W-1:ADDR_W];
   assign r_slot = rsp_tdata[ADDR_W+BLK_W+SLOT_W-1:ADDR_W+BLK_W];
   assign r_off  = rsp_tdata[RSP_FLDS_W-1:ADDR_W+BLK_W+SLOT_W];

   a_rst_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("word valid straight after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result word changed");

   a_err_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_OK |->
         r_addr == ADDR_NONE && r_blk == '0 && r_slot == '0 && r_off == '0)
      else $error("error word carries an address");

   a_split: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && r_addr != ADDR_NONE |->
         rsp_tuser == ST_OK && r_blk == r_addr[IDX_W-1:SLOT_W] &&
         r_slot == r_addr[SLOT_W-1:0])
      else $error("address split mismatch");

endmodule

bind block_grown_free_list_allocator bgfl_checker u_bgfl_checker (.*);
